### rtl/mi3_pkg.sv
`timescale 1ns / 1ps
package mi3_pkg;

	localparam int unsigned N_ENTRIES = 9;

	// cofactor k = m[a]*m[b] - m[c]*m[d], entries in row-major order
	localparam int unsigned COF_IDX [N_ENTRIES][4] = '{
		'{4, 8, 5, 7},
		'{5, 6, 3, 8},
		'{3, 7, 4, 6},
		'{2, 7, 1, 8},
		'{0, 8, 2, 6},
		'{1, 6, 0, 7},
		'{1, 5, 2, 4},
		'{2, 3, 0, 5},
		'{0, 4, 1, 3}
	};

	typedef struct packed {
		logic valid;
		logic singular;
	} mi3_ctl_t;

endpackage

### rtl/mi3_cofactor.sv
`timescale 1ns / 1ps
module mi3_cofactor import mi3_pkg::*; #(
	parameter int DATA_WIDTH = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              en,
	input  logic                              valid,
	input  logic signed [DATA_WIDTH-1:0]      m [N_ENTRIES],
	output logic signed [2*DATA_WIDTH:0]      cof [N_ENTRIES],
	output logic signed [3*DATA_WIDTH+2:0]    det,
	output mi3_ctl_t                          ctl
);

	localparam int PW = 2 * DATA_WIDTH;
	localparam int CW = 2 * DATA_WIDTH + 1;
	localparam int LPW = 2 * DATA_WIDTH + 2;
	localparam int DTW = 3 * DATA_WIDTH + 3;

	logic signed [PW-1:0]         pa_s1 [N_ENTRIES];
	logic signed [PW-1:0]         pb_s1 [N_ENTRIES];
	logic signed [DATA_WIDTH-1:0] row_s1 [3];
	logic signed [CW-1:0]         cof_s2 [N_ENTRIES];
	logic signed [DATA_WIDTH-1:0] row_s2 [3];
	logic signed [LPW-1:0]        lo_s3 [3];
	logic signed [PW-1:0]         hi_s3 [3];
	logic signed [CW-1:0]         cof_s3 [N_ENTRIES];
	logic signed [DTW-1:0]        det_s4;
	logic signed [CW-1:0]         cof_s4 [N_ENTRIES];
	logic [3:0]                   vld_q;
	logic                         sing_q;
	logic signed [DTW-1:0]        det_sum;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < N_ENTRIES; k++) begin
				pa_s1[k] <= PW'(m[COF_IDX[k][0]]) * PW'(m[COF_IDX[k][1]]);
				pb_s1[k] <= PW'(m[COF_IDX[k][2]]) * PW'(m[COF_IDX[k][3]]);
				cof_s2[k] <= CW'(pa_s1[k]) - CW'(pb_s1[k]);
				cof_s3[k] <= cof_s2[k];
				cof_s4[k] <= cof_s3[k];
			end
			// cofactor split into an unsigned low part and a signed high part
			for (int t = 0; t < 3; t++) begin
				row_s1[t] <= m[t];
				row_s2[t] <= row_s1[t];
				lo_s3[t] <= LPW'(row_s2[t]) * LPW'($signed({1'b0, cof_s2[t][DATA_WIDTH:0]}));
				hi_s3[t] <= PW'(row_s2[t]) * PW'($signed(cof_s2[t][CW-1:DATA_WIDTH+1]));
			end
			det_s4 <= det_sum;
		end
	end

	assign det_sum = (DTW'(hi_s3[0]) << (DATA_WIDTH + 1)) + (DTW'(hi_s3[1]) << (DATA_WIDTH + 1))
		+ (DTW'(hi_s3[2]) << (DATA_WIDTH + 1))
		+ DTW'(lo_s3[0]) + DTW'(lo_s3[1]) + DTW'(lo_s3[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			sing_q <= 1'b0;
		end else if (en) begin
			vld_q <= {vld_q[2:0], valid};
			sing_q <= (det_sum == '0);
		end
	end

	assign cof = cof_s4;
	assign det = det_s4;
	assign ctl = '{valid: vld_q[3], singular: sing_q};

endmodule

### rtl/mi3_div_lane.sv
`timescale 1ns / 1ps
module mi3_div_lane import mi3_pkg::*; #(
	parameter int DATA_WIDTH = 32,
	parameter int FRAC_BITS = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           en,
	input  mi3_ctl_t                       ctl_in,
	input  logic signed [2*DATA_WIDTH:0]   adj,
	input  logic signed [3*DATA_WIDTH+2:0] det,
	output mi3_ctl_t                       ctl_out,
	output logic signed [DATA_WIDTH-1:0]   res,
	output logic                           sat
);

	localparam int W = DATA_WIDTH;
	localparam int CW = 2 * W + 1;
	localparam int DTW = 3 * W + 3;
	localparam int NW = CW + 2 * FRAC_BITS + 2;
	localparam int DS = DTW + 1 + W;
	localparam int SW = ((NW > DS) ? NW : DS) + 1;

	logic [CW-1:0]  adj_mag;
	logic [DTW-1:0] det_mag;
	logic [SW-1:0]  num_s1, den_s1;
	logic           neg_s1;
	mi3_ctl_t       ctl_s1;

	logic [SW-1:0]  rem_sk [W+1];
	logic [SW-1:0]  den_sk [W+1];
	logic [W-1:0]   quo_sk [W+1];
	logic           neg_sk [W+1];
	logic           ovf_sk [W+1];
	mi3_ctl_t       ctl_sk [W+1];

	logic [W-1:0]   lim, mag;
	logic           neg_f, sat_c;
	logic signed [W-1:0] res_s;
	logic           sat_s;
	mi3_ctl_t       ctl_s;

	assign adj_mag = adj[CW-1] ? CW'(-adj) : CW'(adj);
	assign det_mag = det[DTW-1] ? DTW'(-det) : DTW'(det);

	// numerator carries the half divisor so the floor rounds to nearest
	always_ff @(posedge clk) begin
		if (en) begin
			num_s1 <= (SW'(adj_mag) << (2 * FRAC_BITS + 1)) + SW'(det_mag);
			den_s1 <= SW'(det_mag) << 1;
			neg_s1 <= adj[CW-1] ^ det[DTW-1];
			rem_sk[0] <= num_s1;
			den_sk[0] <= den_s1;
			quo_sk[0] <= '0;
			neg_sk[0] <= neg_s1;
			ovf_sk[0] <= (num_s1 >= (den_s1 << W));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_sk[0] <= '0;
		end else if (en) begin
			ctl_s1 <= ctl_in;
			ctl_sk[0] <= ctl_s1;
		end
	end

	for (genvar i = 0; i < W; i++) begin : g_step
		localparam int BIT = W - 1 - i;
		logic [SW-1:0] trial;
		logic          take;
		assign trial = den_sk[i] << BIT;
		assign take = (rem_sk[i] >= trial);

		always_ff @(posedge clk) begin
			if (en) begin
				rem_sk[i+1] <= take ? rem_sk[i] - trial : rem_sk[i];
				quo_sk[i+1] <= quo_sk[i] | (take ? (W'(1) << BIT) : '0);
				den_sk[i+1] <= den_sk[i];
				neg_sk[i+1] <= neg_sk[i];
				ovf_sk[i+1] <= ovf_sk[i];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ctl_sk[i+1] <= '0;
			end else if (en) begin
				ctl_sk[i+1] <= ctl_sk[i];
			end
		end
	end

	// a zero quotient is never negative
	always_comb begin
		neg_f = neg_sk[W] && (ovf_sk[W] || (quo_sk[W] != '0));
		lim = neg_f ? (W'(1) << (W - 1)) : ((W'(1) << (W - 1)) - W'(1));
		sat_c = ovf_sk[W] || (quo_sk[W] > lim);
		mag = sat_c ? lim : quo_sk[W];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (ctl_sk[W].singular) begin
				res_s <= '0;
				sat_s <= 1'b0;
			end else begin
				res_s <= neg_f ? signed'(W'(-mag)) : signed'(mag);
				sat_s <= sat_c;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s <= '0;
		end else if (en) begin
			ctl_s <= ctl_sk[W];
		end
	end

	assign res = res_s;
	assign sat = sat_s;
	assign ctl_out = ctl_s;

endmodule

### rtl/matrix_inverse_3x3.sv
`timescale 1ns / 1ps
// 3x3 matrix inverse by the adjugate, signed fixed point.
// input channel: in_valid/in_ready with the nine entries m00..m22, row-major.
// output channel: out_valid/out_ready with inv00..inv22, singular, overflowed.
// one request is taken per cycle while the output side keeps up; results come
// back in request order, one per request.
// products, cofactors, the split determinant terms and the determinant are
// registered in turn; nine divider lanes follow, each an operand register, a
// load register, restoring compare-subtract stages (one per quotient bit) and a
// rounding and saturation stage; one merge register then drives the outputs.
// sustained throughput is one matrix per cycle while the output side keeps up.
// a zero determinant gives all-zero entries with singular set; entries past
// the signed range saturate and set overflowed.
// when out_valid is high and out_ready low, the whole pipeline holds and
// in_ready drops; nothing is lost. asynchronous reset empties the pipeline,
// after which in_ready is high at once.
module matrix_inverse_3x3 import mi3_pkg::*; #(
	parameter int DATA_WIDTH = 32,
	parameter int FRAC_BITS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic signed [DATA_WIDTH-1:0] m00,
	input  logic signed [DATA_WIDTH-1:0] m01,
	input  logic signed [DATA_WIDTH-1:0] m02,
	input  logic signed [DATA_WIDTH-1:0] m10,
	input  logic signed [DATA_WIDTH-1:0] m11,
	input  logic signed [DATA_WIDTH-1:0] m12,
	input  logic signed [DATA_WIDTH-1:0] m20,
	input  logic signed [DATA_WIDTH-1:0] m21,
	input  logic signed [DATA_WIDTH-1:0] m22,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic signed [DATA_WIDTH-1:0] inv00,
	output logic signed [DATA_WIDTH-1:0] inv01,
	output logic signed [DATA_WIDTH-1:0] inv02,
	output logic signed [DATA_WIDTH-1:0] inv10,
	output logic signed [DATA_WIDTH-1:0] inv11,
	output logic signed [DATA_WIDTH-1:0] inv12,
	output logic signed [DATA_WIDTH-1:0] inv20,
	output logic signed [DATA_WIDTH-1:0] inv21,
	output logic signed [DATA_WIDTH-1:0] inv22,
	output logic                         singular,
	output logic                         overflowed
);

	logic                         en;
	logic signed [DATA_WIDTH-1:0] m_arr [N_ENTRIES];
	logic signed [2*DATA_WIDTH:0] cof [N_ENTRIES];
	logic signed [3*DATA_WIDTH+2:0] det;
	mi3_ctl_t                     cof_ctl;
	mi3_ctl_t                     lane_ctl [N_ENTRIES];
	logic signed [DATA_WIDTH-1:0] lane_res [N_ENTRIES];
	logic [N_ENTRIES-1:0]         lane_sat;
	logic signed [DATA_WIDTH-1:0] inv_q [N_ENTRIES];
	logic                         valid_q, sing_q, ovf_q;

	assign en = !valid_q || out_ready;
	assign in_ready = en;

	assign m_arr = '{m00, m01, m02, m10, m11, m12, m20, m21, m22};

	mi3_cofactor #(
		.DATA_WIDTH(DATA_WIDTH)
	) u_cof (
		.clk   (clk),
		.arst_n(arst_n),
		.en    (en),
		.valid (in_valid),
		.m     (m_arr),
		.cof   (cof),
		.det   (det),
		.ctl   (cof_ctl)
	);

	// output (i,j) divides cofactor (j,i)
	for (genvar k = 0; k < N_ENTRIES; k++) begin : g_lane
		mi3_div_lane #(
			.DATA_WIDTH(DATA_WIDTH),
			.FRAC_BITS (FRAC_BITS)
		) u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.ctl_in (cof_ctl),
			.adj    (cof[3 * (k % 3) + k / 3]),
			.det    (det),
			.ctl_out(lane_ctl[k]),
			.res    (lane_res[k]),
			.sat    (lane_sat[k])
		);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			inv_q <= lane_res;
			sing_q <= lane_ctl[0].singular;
			ovf_q <= |lane_sat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= lane_ctl[0].valid;
		end
	end

	assign out_valid = valid_q;
	assign inv00 = inv_q[0];
	assign inv01 = inv_q[1];
	assign inv02 = inv_q[2];
	assign inv10 = inv_q[3];
	assign inv11 = inv_q[4];
	assign inv12 = inv_q[5];
	assign inv20 = inv_q[6];
	assign inv21 = inv_q[7];
	assign inv22 = inv_q[8];
	assign singular = sing_q;
	assign overflowed = ovf_q;

endmodule
